/* sv/lfutt_pkg.sv */
// Package for the LFU tracked id table: request, response and entry types,
// state codes and reset constants. No dependencies.
`default_nettype none

package lfutt_pkg;

  // Default number of table slots and reset value of the window length.
  localparam int unsigned DEF_SLOTS = 8;
  localparam logic [31:0] WINDOW_RESET = 32'd86400000;
  localparam logic [15:0] USE_MAX = 16'hFFFF;

  // Request function codes.
  localparam logic FUNC_USE = 1'b0;
  localparam logic FUNC_PRESENCE = 1'b1;

  // One request as it enters the block.
  typedef struct packed {
    logic        func;
    logic [63:0] user_id;
    logic [31:0] now_time;
    logic [1:0]  new_status;
  } req_t;

  // One response as it leaves the block.
  typedef struct packed {
    logic        applied;
    logic        hit;
    logic        evicted;
    logic [2:0]  slot_index;
    logic [15:0] use_count;
    logic [1:0]  slot_status;
    logic        window_cleared;
  } rsp_t;

  // One word of the entry memory.
  typedef struct packed {
    logic [63:0] id;
    logic [1:0]  presence;
    logic [15:0] uses;
  } entry_t;

  // Summary of a completed scan, handed from the scan unit to the control.
  typedef struct packed {
    logic        match_found;
    logic        free_found;
    logic [1:0]  match_presence;
    logic [15:0] match_uses;
  } scan_sum_t;

  // Control states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_APPLY
  } state_t;

endpackage

`default_nettype wire

/* sv/lfutt_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module lfutt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/lfutt_scan.sv */
// Scan unit: walks the entry words as they come out of the memory and keeps
// the first match, the first free slot and the least-used slot.
// Depends on lfutt_pkg.
`default_nettype none

module lfutt_scan #(
  parameter int unsigned TABLE_SLOTS = lfutt_pkg::DEF_SLOTS,
  localparam int unsigned IDX_W = $clog2(TABLE_SLOTS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 clear,
  input  wire logic [63:0]          key,
  input  wire logic                 rd_vld,
  input  wire logic [IDX_W-1:0]     rd_idx,
  input  wire lfutt_pkg::entry_t    rd_entry,
  input  wire logic                 rd_valid,
  input  wire logic                 rd_uses_ok,
  output lfutt_pkg::scan_sum_t      sum,
  output logic      [IDX_W-1:0]     match_idx,
  output logic      [IDX_W-1:0]     free_idx,
  output logic      [IDX_W-1:0]     min_idx
);

  logic [15:0] cur_uses;
  logic [15:0] min_uses;
  logic        is_match;

  // Counts cleared by a window restart read as zero.
  assign cur_uses = rd_uses_ok ? rd_entry.uses : 16'd0;
  assign is_match = rd_valid && (key != 64'd0) && (rd_entry.id == key);

  // Summary flags, indices and captured data; the first hit of each kind wins.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sum.match_found <= 1'b0;
      sum.free_found  <= 1'b0;
    end else if (rd_vld) begin
      if (is_match) begin
        sum.match_found <= 1'b1;
        if (!sum.match_found) begin
          match_idx          <= rd_idx;
          sum.match_presence <= rd_entry.presence;
          sum.match_uses     <= cur_uses;
        end
      end
      if (!rd_valid) begin
        sum.free_found <= 1'b1;
        if (!sum.free_found) begin
          free_idx <= rd_idx;
        end
      end
      // Strict compare keeps the lowest index on ties.
      if ((rd_idx == '0) || (cur_uses < min_uses)) begin
        min_idx  <= rd_idx;
        min_uses <= cur_uses;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/lfu_tracked_id_table.sv */
// Top level of the LFU tracked id table: control, window logic, valid bits
// and the entry memory. Depends on lfutt_pkg, lfutt_ram and lfutt_scan.
`default_nettype none

// Usage:
//   A request is taken on a rising edge with start high and busy low. The
//   request struct carries func (use or presence update), user_id, now_time
//   and new_status. A use request applies the usage window at the accept edge
//   and then records a nonzero id; a presence request updates a matching slot.
//   Each request yields one response on rsp, marked by done for exactly one
//   cycle. The receiver cannot stall, so done is never held.
//   Sequence: the entry memory is read one slot per cycle in ST_SCAN
//   through its single read port, then ST_LAST finishes the last read and
//   ST_APPLY decides and writes back. The response is registered on rsp as
//   the block leaves ST_APPLY. busy is high in ST_SCAN, ST_LAST and
//   ST_APPLY, and a new request may be accepted at the edge that takes the
//   response, so a request is taken only once the last one is through.
//   The window length register is written with cfg_we and cfg_wdata; the
//   user must do so only while the block is idle; the block does not check.
//   Reset: all slots become free, all counts read zero, the window is not
//   started and the window length returns to 86400000. No memory clearing
//   pass is needed; valid bits in flip-flops cover the entries.
module lfu_tracked_id_table #(
  parameter int unsigned TABLE_SLOTS = lfutt_pkg::DEF_SLOTS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire lfutt_pkg::req_t   req,
  output logic                   busy,
  output logic                   done,
  output lfutt_pkg::rsp_t        rsp,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_wdata
);

  localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
  localparam int unsigned ENT_W = $bits(lfutt_pkg::entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

  lfutt_pkg::state_t state, state_next;

  lfutt_pkg::req_t     cur;
  logic                cur_cleared;
  logic [31:0]         window_start;
  logic [31:0]         window_length;
  logic [TABLE_SLOTS-1:0] valid;
  logic [TABLE_SLOTS-1:0] uses_ok;
  logic [IDX_W-1:0]    addr;
  logic                rd_vld;
  logic [IDX_W-1:0]    rd_idx;
  lfutt_pkg::entry_t   rd_entry;
  lfutt_pkg::scan_sum_t sum;
  logic [IDX_W-1:0]    match_idx;
  logic [IDX_W-1:0]    free_idx;
  logic [IDX_W-1:0]    min_idx;

  logic                accept;
  logic                scanning;
  logic                applying;
  logic [31:0]         elapsed;

  // Decision made in the apply cycle.
  logic                touch;
  logic                dec_hit;
  logic                dec_evict;
  logic [IDX_W-1:0]    slot;
  logic [1:0]          new_pres;
  logic [15:0]         base_uses;
  logic [15:0]         new_uses;
  logic [IDX_W+2:0]    slot_ext;
  lfutt_pkg::entry_t   wr_entry;

  assign accept  = start && !busy;
  assign elapsed = req.now_time - window_start;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      lfutt_pkg::ST_IDLE: begin
        if (start) begin
          state_next = lfutt_pkg::ST_SCAN;
        end
      end
      lfutt_pkg::ST_SCAN: begin
        if (addr == LAST_IDX) begin
          state_next = lfutt_pkg::ST_LAST;
        end
      end
      lfutt_pkg::ST_LAST:  state_next = lfutt_pkg::ST_APPLY;
      lfutt_pkg::ST_APPLY: state_next = lfutt_pkg::ST_IDLE;
      default:             state_next = lfutt_pkg::ST_IDLE;
    endcase
  end

  // State-decoded outputs.
  always_comb begin
    busy     = 1'b1;
    scanning = 1'b0;
    applying = 1'b0;
    case (state)
      lfutt_pkg::ST_IDLE:  busy = 1'b0;
      lfutt_pkg::ST_SCAN:  scanning = 1'b1;
      lfutt_pkg::ST_LAST:  busy = 1'b1;
      lfutt_pkg::ST_APPLY: applying = 1'b1;
      default:             busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfutt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= lfutt_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      window_length <= cfg_wdata;
    end
  end

  // Request capture and the usage window, applied at the accept edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= 32'd0;
      cur_cleared  <= 1'b0;
    end else if (accept) begin
      cur_cleared <= 1'b0;
      if (req.func == lfutt_pkg::FUNC_USE) begin
        if (window_start == 32'd0) begin
          window_start <= req.now_time;
        end else if (elapsed >= window_length) begin
          window_start <= req.now_time;
          cur_cleared  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= req;
    end
  end

  // Scan address and read tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr   <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= scanning;
      if (accept) begin
        addr <= '0;
      end else if (scanning && (addr != LAST_IDX)) begin
        addr <= addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= addr;
  end

  // Slot choice and the entry word written back.
  always_comb begin
    touch     = 1'b0;
    dec_hit   = 1'b0;
    dec_evict = 1'b0;
    slot      = match_idx;
    new_pres  = sum.match_presence;
    base_uses = sum.match_uses;
    new_uses  = sum.match_uses;
    if (cur.func == lfutt_pkg::FUNC_USE) begin
      if (cur.user_id != 64'd0) begin
        touch = 1'b1;
        if (sum.match_found) begin
          dec_hit = 1'b1;
        end else begin
          new_pres  = 2'd0;
          base_uses = 16'd0;
          if (sum.free_found) begin
            slot = free_idx;
          end else begin
            slot      = min_idx;
            dec_evict = 1'b1;
          end
        end
        new_uses = (base_uses == lfutt_pkg::USE_MAX) ? base_uses : base_uses + 16'd1;
      end
    end else if (sum.match_found) begin
      touch    = 1'b1;
      dec_hit  = 1'b1;
      new_pres = cur.new_status;
    end
    slot_ext          = {3'd0, slot};
    wr_entry.id       = cur.user_id;
    wr_entry.presence = new_pres;
    wr_entry.uses     = new_uses;
  end

  // Valid bits and count-valid bits; a window restart clears every count.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      uses_ok <= '0;
    end else if (accept && (req.func == lfutt_pkg::FUNC_USE) &&
                 (window_start != 32'd0) && (elapsed >= window_length)) begin
      uses_ok <= '0;
    end else if (applying && touch) begin
      valid[slot]   <= 1'b1;
      uses_ok[slot] <= 1'b1;
    end
  end

  // Response register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= applying;
    end
  end

  always_ff @(posedge clk) begin
    if (applying) begin
      rsp.applied        <= touch;
      rsp.hit            <= dec_hit;
      rsp.evicted        <= dec_evict;
      rsp.slot_index     <= touch ? slot_ext[2:0] : 3'd0;
      rsp.use_count      <= touch ? new_uses : 16'd0;
      rsp.slot_status    <= touch ? new_pres : 2'd0;
      rsp.window_cleared <= cur_cleared;
    end
  end

  // Entry memory.
  lfutt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (applying && touch),
    .waddr (slot),
    .wdata (wr_entry),
    .raddr (addr),
    .rdata (rd_entry)
  );

  // Scan unit.
  lfutt_scan #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .clear      (accept),
    .key        (cur.user_id),
    .rd_vld     (rd_vld),
    .rd_idx     (rd_idx),
    .rd_entry   (rd_entry),
    .rd_valid   (valid[rd_idx]),
    .rd_uses_ok (uses_ok[rd_idx]),
    .sum        (sum),
    .match_idx  (match_idx),
    .free_idx   (free_idx),
    .min_idx    (min_idx)
  );

endmodule

`default_nettype wire
